// ===== hdl/egta_pkg.sv =====
// ----------------------------------------------------------------------------
// EDF task admission package
// Shared types and constants for the earliest-deadline-first admission block.
// ----------------------------------------------------------------------------
package egta_pkg;

   localparam int MaxTasksDefault = 64;
   localparam int QueueDepth      = 4;

   localparam int TagW  = 16;
   localparam int DurW  = 16;
   localparam int TimeW = 24;

   typedef struct packed {
      logic [TagW-1:0]  tag;
      logic [DurW-1:0]  duration;
      logic [TimeW-1:0] deadline;
   } task_type;

   typedef struct packed {
      task_type item;
      logic     store;
      logic     last;
      logic     overflow;
   } qentry_type;

   typedef struct packed {
      logic     insert;
      logic     shift;
      task_type item;
   } chain_ctl_type;

endpackage

// ===== hdl/egta_queue.sv =====
// ----------------------------------------------------------------------------
// EDF task admission queue
// Short register queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module egta_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  egta_pkg::qentry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output egta_pkg::qentry_type pop_entry
);

   localparam int PtrW = $clog2(egta_pkg::QueueDepth);
   localparam int CntW = $clog2(egta_pkg::QueueDepth + 1);

   egta_pkg::qentry_type slot_ff [egta_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            do_push, do_pop;

   assign push_ready = (fill_ff != CntW'(egta_pkg::QueueDepth));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(egta_pkg::QueueDepth))
      else $error("queue fill exceeds depth");

endmodule

// ===== hdl/egta_chain.sv =====
// ----------------------------------------------------------------------------
// EDF task admission sorted chain
// Row of task cells kept in deadline order; inserts one task per cycle and
// shifts toward the head while the schedule is read out.
// ----------------------------------------------------------------------------
module egta_chain #(
   parameter int MAX_TASKS = egta_pkg::MaxTasksDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  egta_pkg::chain_ctl_type ctl,
   output egta_pkg::task_type      head,
   output logic [$clog2(MAX_TASKS+1)-1:0] count
);

   localparam int CntW = $clog2(MAX_TASKS + 1);

   egta_pkg::task_type cell_ff [MAX_TASKS];
   egta_pkg::task_type cell_in [MAX_TASKS];
   logic [MAX_TASKS-1:0] keep;
   logic [CntW-1:0]      count_ff, count_in;

   genvar i;
   generate
      for (i = 0; i < MAX_TASKS; i++) begin : g_cell
         assign keep[i] = (count_ff > CntW'(i)) &&
                          (cell_ff[i].deadline <= ctl.item.deadline);
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (ctl.shift) begin
               if (i < MAX_TASKS - 1) begin
                  cell_in[i] = cell_ff[(i < MAX_TASKS - 1) ? i + 1 : i];
               end
            end else if (ctl.insert && !keep[i]) begin
               if (i == 0) begin
                  cell_in[i] = ctl.item;
               end else if (keep[(i > 0) ? i - 1 : 0]) begin
                  cell_in[i] = ctl.item;
               end else begin
                  cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end
         always_ff @(posedge clock) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctl.shift) begin
         count_in = count_ff - CntW'(1);
      end else if (ctl.insert) begin
         count_in = count_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = cell_ff[0];
   assign count = count_ff;

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |-> count_ff < CntW'(MAX_TASKS))
      else $error("insert into a full chain");

   a_no_shift_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |-> count_ff != '0)
      else $error("shift of an empty chain");

endmodule

// ===== hdl/egta_walk.sv =====
// ----------------------------------------------------------------------------
// EDF task admission back end
// Loads queued tasks into the chain, then walks it in deadline order and
// issues one admission result per task through an output register.
// ----------------------------------------------------------------------------
module egta_walk #(
   parameter int MAX_TASKS = egta_pkg::MaxTasksDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  egta_pkg::qentry_type     q_entry,
   output logic                    q_pop,
   output egta_pkg::chain_ctl_type  ctl,
   input  egta_pkg::task_type       head,
   input  logic [$clog2(MAX_TASKS+1)-1:0] count,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [egta_pkg::TagW-1:0]  rsp_tag,
   output logic                    rsp_accepted,
   output logic [egta_pkg::TimeW-1:0] rsp_start,
   output logic [egta_pkg::TimeW-1:0] rsp_end,
   output logic                    rsp_overflow,
   output logic                    rsp_last
);

   localparam int CntW  = $clog2(MAX_TASKS + 1);
   localparam int TimeW = egta_pkg::TimeW;

   typedef enum logic {LOAD, WALK} mode_type;

   mode_type           state_ff, state_in;
   logic [TimeW-1:0]   clock_ff, clock_in;
   logic [CntW-1:0]    remaining_ff, remaining_in;
   logic               ovf_ff, ovf_in;
   logic               valid_ff, valid_in;
   logic [egta_pkg::TagW-1:0] tag_ff, tag_in;
   logic               acc_ff, acc_in;
   logic [TimeW-1:0]   start_ff, start_in;
   logic [TimeW-1:0]   end_ff, end_in;
   logic               rovf_ff, rovf_in;
   logic               last_ff, last_in;
   logic               slot_free;
   logic [TimeW:0]     finish;
   logic               fits;

   assign slot_free = !valid_ff || rsp_ready;
   assign finish    = {1'b0, clock_ff} + (TimeW+1)'(head.duration);
   assign fits      = finish <= {1'b0, head.deadline};

   always_comb begin
      state_in     = state_ff;
      clock_in     = clock_ff;
      remaining_in = remaining_ff;
      ovf_in       = ovf_ff;
      valid_in     = valid_ff && !rsp_ready;
      tag_in       = tag_ff;
      acc_in       = acc_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      rovf_in      = rovf_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      ctl.insert   = 1'b0;
      ctl.shift    = 1'b0;
      ctl.item     = q_entry.item;
      case (state_ff)
         LOAD: begin
            q_pop      = q_valid;
            ctl.insert = q_valid && q_entry.store;
            if (q_valid && q_entry.last) begin
               state_in     = WALK;
               clock_in     = '0;
               remaining_in = count + CntW'(q_entry.store);
               ovf_in       = q_entry.overflow;
            end
         end
         WALK: begin
            if (slot_free) begin
               ctl.shift    = 1'b1;
               valid_in     = 1'b1;
               tag_in       = head.tag;
               acc_in       = fits;
               start_in     = fits ? clock_ff : '0;
               end_in       = fits ? finish[TimeW-1:0] : '0;
               rovf_in      = ovf_ff;
               last_in      = (remaining_ff == CntW'(1));
               remaining_in = remaining_ff - CntW'(1);
               if (fits) begin
                  clock_in = finish[TimeW-1:0];
               end
               if (remaining_ff == CntW'(1)) begin
                  state_in = LOAD;
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         clock_ff     <= '0;
         remaining_ff <= '0;
         ovf_ff       <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         remaining_ff <= remaining_in;
         ovf_ff       <= ovf_in;
         valid_ff     <= valid_in;
      end
      tag_ff   <= tag_in;
      acc_ff   <= acc_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      rovf_ff  <= rovf_in;
      last_ff  <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_tag      = tag_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_start    = start_ff;
   assign rsp_end      = end_ff;
   assign rsp_overflow = rovf_ff;
   assign rsp_last     = last_ff;

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == WALK |-> remaining_ff != '0 && remaining_ff == count)
      else $error("walk count out of step with chain");

   a_no_pop_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == WALK |-> !q_pop && !ctl.insert)
      else $error("queue drained during walk");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == WALK && slot_free && remaining_ff == CntW'(1)
      |=> state_ff == LOAD && count == '0 && rsp_last)
      else $error("walk did not end on its last result");

endmodule

// ===== hdl/edf_greedy_task_admission.sv =====
// ----------------------------------------------------------------------------
// EDF greedy task admission
// Front end classifies incoming tasks against capacity and queues them; the
// back end sorts them by deadline and issues greedy admission results.
// ----------------------------------------------------------------------------
// Tasks are taken one per cycle while the four-entry queue has room; a task
// is first written to a queue slot and then inserted into the sorted chain.
// The first result is registered after the last task of a set reaches the
// chain, then one per cycle while rsp_tready holds, one per stored task.
// While a set is walked out, the front end keeps queueing the next set.
// Synchronous reset empties the queue and chain and clears all counters.
// ----------------------------------------------------------------------------
module edf_greedy_task_admission #(
   parameter int MAX_TASKS = egta_pkg::MaxTasksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // task_tag, duration, deadline
   input  logic        req_tlast,   // last_task
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_tag, start_time, end_time
   output logic [1:0]  rsp_tuser,   // accepted, overflow
   output logic        rsp_tlast    // last_result
);

   localparam int CntW = $clog2(MAX_TASKS + 1);

   logic [CntW-1:0]          set_cnt_ff, set_cnt_in;
   logic                     drop_ff, drop_in;
   logic                     req_fire;
   logic                     fits_room;
   egta_pkg::qentry_type     push_entry;
   egta_pkg::qentry_type     q_entry;
   logic                     q_valid, q_pop;
   egta_pkg::chain_ctl_type  ctl;
   egta_pkg::task_type       head;
   logic [CntW-1:0]          count;
   logic [egta_pkg::TagW-1:0]  tag;
   logic [egta_pkg::TimeW-1:0] start_t, end_t;
   logic                     accepted, overflow;

   assign req_fire  = req_tvalid && req_tready;
   assign fits_room = set_cnt_ff < CntW'(MAX_TASKS);

   always_comb begin
      push_entry.item.tag      = req_tdata[15:0];
      push_entry.item.duration = req_tdata[31:16];
      push_entry.item.deadline = req_tdata[55:32];
      push_entry.store         = fits_room;
      push_entry.last          = req_tlast;
      push_entry.overflow      = drop_ff || !fits_room;
      set_cnt_in               = set_cnt_ff;
      drop_in                  = drop_ff;
      if (req_fire) begin
         if (req_tlast) begin
            set_cnt_in = '0;
            drop_in    = 1'b0;
         end else begin
            set_cnt_in = set_cnt_ff + CntW'(fits_room);
            drop_in    = drop_ff || !fits_room;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_cnt_ff <= '0;
         drop_ff    <= 1'b0;
      end else begin
         set_cnt_ff <= set_cnt_in;
         drop_ff    <= drop_in;
      end
   end

   egta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_entry (push_entry),
      .push_ready (req_tready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   egta_chain #(
      .MAX_TASKS (MAX_TASKS)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .head  (head),
      .count (count)
   );

   egta_walk #(
      .MAX_TASKS (MAX_TASKS)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .ctl          (ctl),
      .head         (head),
      .count        (count),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_tag      (tag),
      .rsp_accepted (accepted),
      .rsp_start    (start_t),
      .rsp_end      (end_t),
      .rsp_overflow (overflow),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {end_t, start_t, tag};
   assign rsp_tuser = {overflow, accepted};

endmodule
